// ===== hdl/skyline_atlas_allocator_assert.svh =====
// assertion macros for the skyline atlas allocator
// included by the top level; no other dependencies
`ifndef SKYLINE_ATLAS_ALLOCATOR_ASSERT_SVH
`define SKYLINE_ATLAS_ALLOCATOR_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define SKYATL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define SKYATL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/skyatl_pkg.sv =====
// shared types and constants for the skyline atlas allocator
// no dependencies
package skyatl_pkg;

    // default geometry
    localparam int DEF_ATLAS_SIDE   = 512;
    localparam int DEF_ATLAS_LAYERS = 16;

    // fixed field widths
    localparam int BLK_W   = 10;
    localparam int POS_W   = 9;
    localparam int LAYER_W = 4;

    typedef enum logic {
        KIND_PLACE = 1'b0,
        KIND_CLEAR = 1'b1
    } kind_t;

    typedef enum logic {
        STATUS_OK   = 1'b0,
        STATUS_FULL = 1'b1
    } status_t;

    // request beat
    typedef struct packed {
        kind_t              kind;
        logic [BLK_W-1:0]   block_width;
        logic [BLK_W-1:0]   block_height;
    } req_t;

    // response beat
    typedef struct packed {
        status_t            status;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [LAYER_W-1:0] layer_index;
    } rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic clear_all;
        logic clr_init;
        logic clr_step;
        logic mark_valid;
        logic scan_init;
        logic sky_rd;
        logic pop;
        logic push;
        logic next_layer;
        logic raise_init;
        logic raise_step;
        logic load_out;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic kind_clear;
        logic layer_spent;
        logic layer_valid;
        logic clr_last;
        logic do_pop;
        logic x_zero;
        logic fit_ok;
        logic raise_done;
        logic out_free;
    } sts_t;

endpackage

// ===== hdl/skyatl_ctrl.sv =====
// control state machine for the skyline atlas allocator
// depends on skyatl_pkg
module skyatl_ctrl
    import skyatl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_CLR,
        S_SCAN,
        S_RD,
        S_CMP,
        S_POPW,
        S_FIT,
        S_RAISE,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && ready_reg)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                if (sts.kind_clear)
                begin
                    cmd.clear_all = 1'b1;
                    state_next    = S_RESULT;
                end
                else if (sts.layer_spent)
                begin
                    state_next = S_RESULT;
                end
                else if (!sts.layer_valid)
                begin
                    cmd.clr_init = 1'b1;
                    state_next   = S_CLR;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    cmd.mark_valid = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_init = 1'b1;
                state_next    = S_RD;
            end
            S_RD:
            begin
                cmd.sky_rd = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (sts.do_pop)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_POPW;
                end
                else
                begin
                    cmd.push   = 1'b1;
                    state_next = sts.x_zero ? S_FIT : S_RD;
                end
            end
            S_POPW:
            begin
                state_next = S_CMP;
            end
            S_FIT:
            begin
                if (sts.fit_ok)
                begin
                    cmd.raise_init = 1'b1;
                    state_next     = S_RAISE;
                end
                else
                begin
                    cmd.next_layer = 1'b1;
                    state_next     = S_START;
                end
            end
            S_RAISE:
            begin
                if (sts.raise_done)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.raise_step = 1'b1;
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign ready_next = (state_next == S_IDLE);

    // state and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign req_ready = ready_reg;

endmodule

// ===== hdl/skyatl_dp.sv =====
// datapath for the skyline atlas allocator: height memory, scan stack, output register
// depends on skyatl_pkg
module skyatl_dp
    import skyatl_pkg::*;
#(
    parameter int ATLAS_SIDE   = DEF_ATLAS_SIDE,
    parameter int ATLAS_LAYERS = DEF_ATLAS_LAYERS
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int CW    = $clog2(ATLAS_SIDE);
    localparam int HW    = $clog2(ATLAS_SIDE + 1);
    localparam int SPW   = HW;
    localparam int LW    = (ATLAS_LAYERS > 1) ? $clog2(ATLAS_LAYERS) : 1;
    localparam int LCW   = $clog2(ATLAS_LAYERS + 1);
    localparam int DEPTH = ATLAS_LAYERS * ATLAS_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = ((HW > BLK_W) ? HW : BLK_W) + 1;

    localparam logic [CW-1:0]  COL_LAST  = CW'(ATLAS_SIDE - 1);
    localparam logic [LCW-1:0] LAYER_END = LCW'(ATLAS_LAYERS);
    localparam logic [EW-1:0]  SIDE_E    = EW'(ATLAS_SIDE);
    localparam logic [EW-1:0]  SIDE_M1_E = EW'(ATLAS_SIDE - 1);
    localparam logic [AW-1:0]  SIDE_A    = AW'(ATLAS_SIDE);

    // captured request
    kind_t            kind_reg;
    logic [BLK_W-1:0] w_reg;
    logic [BLK_W-1:0] h_reg;

    // layer bookkeeping
    logic [LCW-1:0]          layer_reg;
    logic [AW-1:0]           base_reg;
    logic [ATLAS_LAYERS-1:0] lvalid_reg;

    // scan state
    logic [CW-1:0]  col_reg;
    logic [SPW-1:0] sp_reg;
    logic [CW-1:0]  top_idx_reg;
    logic [HW-1:0]  top_h_reg;
    logic           found_reg;
    logic [CW-1:0]  best_x_reg;
    logic [HW-1:0]  best_h_reg;
    logic [SPW-1:0] cnt_reg;

    // memories and their read registers
    logic [HW-1:0]    sky_mem [DEPTH];
    logic [CW+HW-1:0] stk_mem [ATLAS_SIDE];
    logic [HW-1:0]    sky_rd_reg;
    logic [CW+HW-1:0] stk_rd_reg;

    logic rsp_valid_reg;
    rsp_t rsp_reg;

    logic [AW-1:0] sky_addr;
    logic [CW-1:0] stk_wr_addr;
    logic [CW-1:0] stk_rd_addr;
    logic [EW-1:0] ng_e;
    logic [EW-1:0] span_e;
    logic [EW-1:0] fit_sum;
    logic          qualify;
    logic          better;
    logic          placed;
    logic          spent;

    assign sky_addr    = base_reg + AW'(col_reg);
    assign stk_wr_addr = CW'(sp_reg - SPW'(1));
    assign stk_rd_addr = CW'(sp_reg - SPW'(2));

    // next strictly higher column to the right, or the atlas edge
    assign ng_e    = (sp_reg != '0) ? EW'(top_idx_reg) : SIDE_E;
    assign span_e  = ng_e - EW'(col_reg);
    assign qualify = (EW'(sky_rd_reg) < SIDE_M1_E) && (span_e >= EW'(w_reg));
    assign better  = !found_reg || (sky_rd_reg <= best_h_reg);
    assign fit_sum = EW'(best_h_reg) + EW'(h_reg);
    assign spent   = (layer_reg == LAYER_END);
    assign placed  = (kind_reg == KIND_PLACE) && !spent;

    // status back to the controller
    always_comb
    begin
        sts.kind_clear  = (kind_reg == KIND_CLEAR);
        sts.layer_spent = spent;
        sts.layer_valid = lvalid_reg[layer_reg[LW-1:0]];
        sts.clr_last    = (col_reg == COL_LAST);
        sts.do_pop      = (sp_reg != '0) && (top_h_reg <= sky_rd_reg);
        sts.x_zero      = (col_reg == '0);
        sts.fit_ok      = found_reg && (fit_sum <= SIDE_E);
        sts.raise_done  = (cnt_reg == '0);
        sts.out_free    = !rsp_valid_reg || rsp_ready;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_reg     <= '0;
            base_reg      <= '0;
            lvalid_reg    <= '0;
            sp_reg        <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_all)
            begin
                layer_reg  <= '0;
                base_reg   <= '0;
                lvalid_reg <= '0;
            end
            else if (cmd.next_layer)
            begin
                layer_reg <= layer_reg + LCW'(1);
                base_reg  <= base_reg + SIDE_A;
            end
            if (cmd.mark_valid)
            begin
                lvalid_reg[layer_reg[LW-1:0]] <= 1'b1;
            end
            // stack depth and best candidate
            if (cmd.scan_init)
            begin
                sp_reg    <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.pop)
            begin
                sp_reg <= sp_reg - SPW'(1);
            end
            else if (cmd.push)
            begin
                sp_reg <= sp_reg + SPW'(1);
                if (qualify && better)
                begin
                    found_reg <= 1'b1;
                end
            end
            // output register
            if (cmd.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= req.kind;
            w_reg    <= req.block_width;
            h_reg    <= req.block_height;
        end
        // column pointer shared by clear sweep, scan and raise
        if (cmd.clr_init)
        begin
            col_reg <= '0;
        end
        else if (cmd.clr_step || cmd.raise_step)
        begin
            col_reg <= col_reg + CW'(1);
        end
        else if (cmd.scan_init)
        begin
            col_reg <= COL_LAST;
        end
        else if (cmd.push && (col_reg != '0))
        begin
            col_reg <= col_reg - CW'(1);
        end
        else if (cmd.raise_init)
        begin
            col_reg <= best_x_reg;
        end
        // top of stack
        if (cmd.pop)
        begin
            {top_idx_reg, top_h_reg} <= stk_rd_reg;
        end
        else if (cmd.push)
        begin
            top_idx_reg <= col_reg;
            top_h_reg   <= sky_rd_reg;
            if (qualify && better)
            begin
                best_x_reg <= col_reg;
                best_h_reg <= sky_rd_reg;
            end
        end
        // columns left to raise
        if (cmd.raise_init)
        begin
            cnt_reg <= SPW'(w_reg);
        end
        else if (cmd.raise_step)
        begin
            cnt_reg <= cnt_reg - SPW'(1);
        end
        if (cmd.load_out)
        begin
            rsp_reg.status      <= ((kind_reg == KIND_PLACE) && spent) ? STATUS_FULL
                                                                        : STATUS_OK;
            rsp_reg.pos_x       <= placed ? POS_W'(best_x_reg) : '0;
            rsp_reg.pos_y       <= placed ? POS_W'(best_h_reg) : '0;
            rsp_reg.layer_index <= placed ? LAYER_W'(layer_reg) : '0;
        end
    end

    // column height memory write port
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            sky_mem[sky_addr] <= '0;
        end
        else if (cmd.raise_step)
        begin
            sky_mem[sky_addr] <= fit_sum[HW-1:0];
        end
    end

    // column height memory read port
    always_ff @(posedge clk)
    begin
        if (cmd.sky_rd)
        begin
            sky_rd_reg <= sky_mem[sky_addr];
        end
    end

    // scan stack: entries below the top live in memory
    always_ff @(posedge clk)
    begin
        if (cmd.push && (sp_reg != '0))
        begin
            stk_mem[stk_wr_addr] <= {top_idx_reg, top_h_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (sp_reg >= SPW'(2))
        begin
            stk_rd_reg <= stk_mem[stk_rd_addr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hdl/skyline_atlas_allocator.sv =====
// Skyline atlas allocator. One request channel (req_valid/req_ready/req) and one
// response channel (rsp_valid/rsp_ready/rsp); every request beat yields one response.
// A place request scans the current layer right to left, one column height per read,
// keeping a stack of still-higher columns to find for each column how far it can
// extend; the lowest fitting column (leftmost on ties) wins, then its columns are raised.
// A clear, or a place refused with every layer spent, goes straight from the request beat
// to loading its response. A place scans each layer tried, with the stack pops that the
// scan needs, then raises the columns of the winning spot and loads the response.
// A layer that is used for the first time since reset or a clear is swept to zero first,
// so no sweep runs at reset. After reset all layers are empty and layer 0 is current. One
// request is worked on at a time; the next is taken as soon as the previous response sits
// in the output register, even while rsp_ready is low. A stalled receiver holds the
// response and blocks only the loading of the next one.
// Depends on skyatl_pkg, skyatl_ctrl, skyatl_dp and the assertion macro header.
`include "skyline_atlas_allocator_assert.svh"

module skyline_atlas_allocator
    import skyatl_pkg::*;
#(
    parameter int ATLAS_SIDE   = DEF_ATLAS_SIDE,
    parameter int ATLAS_LAYERS = DEF_ATLAS_LAYERS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    cmd_t cmd;
    sts_t sts;

    // sequencing
    skyatl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // storage and arithmetic
    skyatl_dp #(
        .ATLAS_SIDE   (ATLAS_SIDE),
        .ATLAS_LAYERS (ATLAS_LAYERS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // checks
    `SKYATL_ASSERT_NEXT(a_one_item_at_a_time, clk, rst_n, req_valid && req_ready, !req_ready, "request taken while busy")
    `SKYATL_ASSERT_NOW(a_load_into_free_slot, clk, rst_n, cmd.load_out, !rsp_valid || rsp_ready, "response overwritten")
    `SKYATL_ASSERT_NOW(a_full_carries_zeros, clk, rst_n, rsp_valid && (rsp.status == STATUS_FULL), (rsp.pos_x == '0) && (rsp.pos_y == '0) && (rsp.layer_index == '0), "full response not zeroed")

endmodule

// ===== tb/atlas_pack_checker.sv =====
// checker for the skyline atlas allocator: watches both channels, predicts every response
// and compares it field by field with what the block returns
// depends on skyatl_pkg for the beat types, the field widths and the default geometry
module atlas_pack_checker
    import skyatl_pkg::*;
#(
    parameter int SIDE   = DEF_ATLAS_SIDE,
    parameter int LAYERS = DEF_ATLAS_LAYERS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   fails,
    output int   awaiting,
    output int   placed_cnt,
    output int   full_cnt,
    output int   clear_cnt
);
    timeunit 1ns;
    timeprecision 1ps;

    // own copy of the skyline heights and the first layer still in use
    logic [BLK_W-1:0] sky_h [LAYERS][SIDE];
    int unsigned      live_layer;

    // responses predicted for accepted request beats, oldest first
    rsp_t             pending_replies[$];

    // flatten every layer and go back to layer 0
    function automatic void wipe_atlas();
        int lay;
        int col;
        for (lay = 0; lay < LAYERS; lay++)
            for (col = 0; col < SIDE; col++)
                sky_h[lay][col] = '0;
        live_layer = 0;
    endfunction

    // search one layer for the leftmost lowest spot; raise the columns on success
    function automatic bit fit_in_layer(input int unsigned lay, input int unsigned w,
                                        input int unsigned h, output int unsigned px,
                                        output int unsigned py);
        int unsigned x;
        int unsigned k;
        int unsigned d;
        int unsigned best;
        int unsigned best_h;
        bit          found;
        bit          fits;
        found  = 1'b0;
        best   = 0;
        best_h = 0;
        px     = 0;
        py     = 0;
        for (x = 0; x < SIDE; x++)
        begin
            d = sky_h[lay][x];
            if (d >= SIDE - 1)
                continue;
            if (found && d >= best_h)
                continue;
            // every column under the window must lie inside and be no higher
            fits = 1'b1;
            for (k = 0; k < w; k++)
            begin
                if (x + k > SIDE - 1 || sky_h[lay][x + k] > d)
                begin
                    fits = 1'b0;
                    break;
                end
            end
            if (fits)
            begin
                found  = 1'b1;
                best   = x;
                best_h = d;
            end
        end
        if (!found || best_h + h > SIDE)
            return 1'b0;
        for (x = best; x < best + w; x++)
            sky_h[lay][x] = BLK_W'(best_h + h);
        px = best;
        py = best_h;
        return 1'b1;
    endfunction

    // work out the response to one request beat, moving to later layers on failure
    function automatic rsp_t pack_request(input req_t r);
        rsp_t        o;
        int unsigned px;
        int unsigned py;
        o = '0;
        o.status = STATUS_OK;
        if (r.kind == KIND_CLEAR)
        begin
            wipe_atlas();
            return o;
        end
        while (live_layer < LAYERS)
        begin
            if (fit_in_layer(live_layer, r.block_width, r.block_height, px, py))
            begin
                o.pos_x       = px[POS_W-1:0];
                o.pos_y       = py[POS_W-1:0];
                o.layer_index = live_layer[LAYER_W-1:0];
                return o;
            end
            live_layer++;
        end
        o.status = STATUS_FULL;
        return o;
    endfunction

    initial
    begin
        fails      = 0;
        placed_cnt = 0;
        full_cnt   = 0;
        clear_cnt  = 0;
        awaiting   = 0;
        wipe_atlas();
    end

    // response beats are matched before the request beat of the same edge is predicted
    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        req_t r;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                got = rsp;
                if (pending_replies.size() == 0)
                begin
                    $error("response beat with no request outstanding: %p", got);
                    fails++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fails++;
                    end
                    if (got.pos_x !== want.pos_x)
                    begin
                        $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
                        fails++;
                    end
                    if (got.pos_y !== want.pos_y)
                    begin
                        $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
                        fails++;
                    end
                    if (got.layer_index !== want.layer_index)
                    begin
                        $error("layer_index: expected %0d, got %0d",
                               want.layer_index, got.layer_index);
                        fails++;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                r    = req;
                want = pack_request(r);
                pending_replies.push_back(want);
                if (r.kind == KIND_CLEAR)
                    clear_cnt++;
                else if (want.status == STATUS_FULL)
                    full_cnt++;
                else
                    placed_cnt++;
            end
            awaiting <= pending_replies.size();
        end
    end

endmodule

// ===== tb/tb_skyline_atlas_allocator.sv =====
// top of the skyline atlas allocator testbench: clock, reset, request and response traffic
// depends on skyatl_pkg, the allocator RTL and atlas_pack_checker
module tb_skyline_atlas_allocator;
    timeunit 1ns;
    timeprecision 1ps;
    import skyatl_pkg::*;

    localparam int RANDOM_ITEMS = 118;
    localparam int LONG_HOLD    = 9000;
    localparam int HOLD_AT_BEAT = 60;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    int   fails;
    int   awaiting;
    int   placed_cnt;
    int   full_cnt;
    int   clear_cnt;
    int   sent = 0;
    bit   calm = 1'b0;

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    skyline_atlas_allocator u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    atlas_pack_checker u_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .fails      (fails),
        .awaiting   (awaiting),
        .placed_cnt (placed_cnt),
        .full_cnt   (full_cnt),
        .clear_cnt  (clear_cnt)
    );

    // idle length: mostly none or short, now and then long; none at all in calm stretches
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // offer one request beat after a random gap and hold it until taken
    task automatic push_req(input kind_t k, input int w, input int h);
        req_t r;
        int   gap;
        r.kind         = k;
        r.block_width  = w[BLK_W-1:0];
        r.block_height = h[BLK_W-1:0];
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        sent++;
    endtask

    // response side: random stalls per beat, one long hold to back the block up
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (rsp_valid)
            begin
                if (taken == HOLD_AT_BEAT)
                    stall = LONG_HOLD;
                else
                    stall = pick_gap();
                if (stall > 0)
                begin
                    rsp_ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
                rsp_ready <= 1'b1;
                do
                    @(posedge clk);
                while (!(rsp_valid && rsp_ready));
                taken++;
            end
        end
    end

    // watchdog
    initial
    begin
        #100_000_000;
        $display("status: fail");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        int i;
        int roll;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // first layer: single cell, empty window, full-width strip, zero height
        push_req(KIND_PLACE, 1, 1);
        push_req(KIND_PLACE, 0, 0);
        push_req(KIND_PLACE, 512, 1);
        push_req(KIND_PLACE, 7, 0);
        // tall column up to side-1, then a block that no longer fits vertically
        push_req(KIND_PLACE, 3, 509);
        push_req(KIND_PLACE, 2, 1);
        push_req(KIND_PLACE, 4, 511);
        // width beyond the atlas spends every layer, then requests stay refused
        push_req(KIND_PLACE, 513, 1);
        push_req(KIND_PLACE, 1023, 1023);
        push_req(KIND_PLACE, 1, 1);
        push_req(KIND_CLEAR, 0, 0);
        // whole layers filled, then a layer with no qualifying column
        push_req(KIND_PLACE, 512, 512);
        push_req(KIND_PLACE, 512, 512);
        push_req(KIND_PLACE, 0, 0);
        push_req(KIND_PLACE, 1, 512);
        push_req(KIND_PLACE, 1, 511);
        push_req(KIND_PLACE, 510, 1);
        push_req(KIND_PLACE, 1, 510);
        push_req(KIND_CLEAR, 1023, 1023);
        push_req(KIND_PLACE, 1, 1);
        push_req(KIND_PLACE, 256, 300);
        push_req(KIND_PLACE, 256, 300);

        // random traffic, mostly well-formed placements with the odd clear or oversize beat
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 25 == 0)
                calm = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 5)
                push_req(KIND_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023));
            else if (roll < 8)
            begin
                if ($urandom_range(0, 1) == 1)
                    push_req(KIND_PLACE, $urandom_range(513, 1023), $urandom_range(0, 512));
                else
                    push_req(KIND_PLACE, $urandom_range(0, 512), $urandom_range(513, 1023));
            end
            else if (roll < 16)
                push_req(KIND_PLACE, $urandom_range(128, 512), $urandom_range(128, 512));
            else if (roll < 20)
                push_req(KIND_PLACE, $urandom_range(0, 2), $urandom_range(0, 2));
            else
                push_req(KIND_PLACE, $urandom_range(1, 64), $urandom_range(1, 64));
        end
        @(negedge clk);
        req_valid <= 1'b0;

        // drain
        wait (awaiting == 0);
        repeat (16) @(posedge clk);

        $display("%0d request beats: %0d placed, %0d clears, %0d refused with the atlas full",
                 sent, placed_cnt, clear_cnt, full_cnt);
        $display("one receiver hold of %0d cycles backed the block up", LONG_HOLD);
        if (fails == 0 && awaiting == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== skyline_atlas_allocator.f =====
+incdir+hdl
hdl/skyatl_pkg.sv
hdl/skyatl_ctrl.sv
hdl/skyatl_dp.sv
hdl/skyline_atlas_allocator.sv
tb/atlas_pack_checker.sv
tb/tb_skyline_atlas_allocator.sv
